// File: sv/assert_macros.svh
// shared assertion helpers; clk and arst_n must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEXT(name, ante, cons, msg) \
	`ASSERT_AT_CLK(name, (ante) |=> (cons), msg)

`endif

// File: sv/stp_cbe_pkg.sv
package stp_cbe_pkg;

	localparam int NUM_PORTS_DEF = 8;

	localparam logic [63:0] BRIDGE_ID_RST = 64'd0;
	localparam logic [7:0]  PORT_PRIO_RST = 8'd128;
	localparam logic [3:0]  PORTS_USE_RST = 4'd8;
	localparam logic [15:0] PATH_COST_RST = 16'd1;

	typedef enum logic [1:0] {
		REG_BRIDGE_ID = 2'd0,
		REG_PORT_PRIO = 2'd1,
		REG_PORTS_USE = 2'd2,
		REG_PATH_COST = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] root;
		logic [31:0] cost;
		logic [63:0] bridge;
		logic [15:0] did;
	} rec_t;

	typedef struct packed {
		logic init;
		logic shift;
	} cell_ctl_t;

	function automatic logic [15:0] own_id(logic [7:0] prio, logic [7:0] idx);
		return {prio, idx + 8'd1};
	endfunction

endpackage

// File: sv/stp_config_bpdu_engine.sv
// channel  | handshake          | fields
// config   | psel/penable/pwrite| paddr, pwdata, prdata (64-bit, 8-byte stride)
// input    | start & !busy      | operation, rx_port, rx_root_id, rx_root_cost,
//          |                    | rx_bridge_id, rx_port_id
// result   | tx_valid strobe    | tx_port, tx_root_id, tx_root_cost, tx_port_id, last
//
// Port records sit in a ring of cells that rotates one step per cycle during a
// compare, election or update pass; the controller works on the cell at the head.
// A received config that is better runs a compare pass, an election pass and an
// update/send pass, otherwise only the compare pass; a hello tick runs the update/send
// pass (none while the hello flag is clear); an ignored item runs no pass.
// After reset and after every register write all records are reloaded.
// Results are one-cycle strobes; the receiver cannot stall them.
`include "assert_macros.svh"

module stp_config_bpdu_engine import stp_cbe_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [2:0]  rx_port,
	input  logic [63:0] rx_root_id,
	input  logic [31:0] rx_root_cost,
	input  logic [63:0] rx_bridge_id,
	input  logic [15:0] rx_port_id,
	output logic        tx_valid,
	output logic [2:0]  tx_port,
	output logic [63:0] tx_root_id,
	output logic [31:0] tx_root_cost,
	output logic [15:0] tx_port_id,
	output logic        last
);

	localparam int IW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int NW = $clog2(NUM_PORTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CMP, ST_ELECT, ST_FIN, ST_UPD, ST_FLUSH
	} state_t;

	state_t      state_q;
	logic        init_q;
	logic [IW-1:0] cnt_q;
	logic [63:0] bridge_id_q;
	logic [7:0]  prio_q;
	logic [3:0]  ports_use_q;
	logic [15:0] path_cost_q;
	logic [63:0] root_id_q;
	logic [31:0] root_cost_q;
	logic        rpv_q;
	logic        hello_q;
	logic        better_q;
	logic        found_q;
	logic        do_upd_q;
	logic        pend_v_q;
	logic [IW-1:0] pend_idx_q;
	rec_t        best_q;
	rec_t        rx_q;
	logic [2:0]  rxp_q;
	logic        tx_valid_q;
	logic [2:0]  tx_port_q;
	logic [63:0] tx_root_id_q;
	logic [31:0] tx_root_cost_q;
	logic [15:0] tx_port_id_q;
	logic        last_q;

	rec_t      rec [NUM_PORTS];
	rec_t      head;
	rec_t      head_new;
	cell_ctl_t cctl;

	logic [NW-1:0] np;
	logic        in_use, desig, better, wins, take, sendable, emit_now, at_p, last_cnt;
	logic        cfg_wr, accept, rx_ok;
	logic [15:0] head_own;
	logic [63:0] nr_id;
	logic [31:0] nr_cost;

	assign cctl.init  = init_q;
	assign cctl.shift = (state_q == ST_CMP) || (state_q == ST_ELECT) || (state_q == ST_UPD);

	for (genvar k = 0; k < NUM_PORTS; k++) begin : g_ring
		rec_t nxt;
		rec_t irec;
		if (k == NUM_PORTS - 1) begin : g_tail
			assign nxt = head_new;
		end else begin : g_mid
			assign nxt = rec[k+1];
		end
		assign irec = '{root: bridge_id_q, cost: 32'd0, bridge: bridge_id_q,
			did: own_id(prio_q, 8'(k))};
		stp_cbe_cell u_cell (
			.clk      (clk),
			.ctl      (cctl),
			.init_rec (irec),
			.nxt_rec  (nxt),
			.rec      (rec[k])
		);
	end

	assign head = rec[0];

	always_comb begin
		if (ports_use_q == 4'd0) begin
			np = NW'(1);
		end else if (int'(ports_use_q) > NUM_PORTS) begin
			np = NW'(NUM_PORTS);
		end else begin
			np = NW'(ports_use_q);
		end
	end

	assign head_own = own_id(prio_q, 8'(cnt_q));
	assign in_use   = NW'(cnt_q) < np;
	assign desig    = (head.bridge == bridge_id_q) && (head.did == head_own);
	assign at_p     = 8'(cnt_q) == 8'(rxp_q);
	assign last_cnt = cnt_q == IW'(NUM_PORTS - 1);
	assign sendable = (root_id_q == bridge_id_q) || rpv_q;
	assign rx_ok    = 32'(rx_port) < 32'(np);

	always_comb begin
		if (head.root != rx_q.root) begin
			better = head.root > rx_q.root;
		end else if (head.cost != rx_q.cost) begin
			better = head.cost > rx_q.cost;
		end else if (head.bridge != rx_q.bridge) begin
			better = head.bridge[47:0] > rx_q.bridge[47:0];
		end else if (head.did != rx_q.did) begin
			better = head.did[7:0] > rx_q.did[7:0];
		end else begin
			better = 1'b0;
		end
	end

	always_comb begin
		if (head.root != best_q.root) begin
			wins = head.root < best_q.root;
		end else if (head.cost != best_q.cost) begin
			wins = head.cost < best_q.cost;
		end else if (head.bridge != best_q.bridge) begin
			wins = !(head.bridge[47:0] > best_q.bridge[47:0]);
		end else if (head.did != best_q.did) begin
			wins = !(head.did[7:0] > best_q.did[7:0]);
		end else begin
			wins = 1'b1;
		end
	end

	assign take = (root_cost_q < head.cost)
		|| ((root_cost_q == head.cost) && (bridge_id_q < head.bridge))
		|| ((root_cost_q == head.cost) && (bridge_id_q == head.bridge)
			&& (head_own == head.did));

	always_comb begin
		head_new = head;
		case (state_q)
			ST_CMP: begin
				if (at_p && better) begin
					head_new = rx_q;
				end
			end
			ST_UPD: begin
				if (in_use && do_upd_q) begin
					if (desig) begin
						head_new.root = root_id_q;
						head_new.cost = root_cost_q;
					end else if (take) begin
						head_new = '{root: root_id_q, cost: root_cost_q,
							bridge: bridge_id_q, did: head_own};
					end
				end
			end
			default: begin
				head_new = head;
			end
		endcase
	end

	assign emit_now = in_use && (desig || (do_upd_q && take)) && sendable;
	assign nr_id    = found_q ? best_q.root : bridge_id_q;
	assign nr_cost  = found_q ? best_q.cost + {16'd0, path_cost_q} : 32'd0;

	assign cfg_wr = psel && penable && pwrite;
	assign busy   = (state_q != ST_IDLE) || init_q;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			init_q         <= 1'b1;
			cnt_q          <= '0;
			bridge_id_q    <= BRIDGE_ID_RST;
			prio_q         <= PORT_PRIO_RST;
			ports_use_q    <= PORTS_USE_RST;
			path_cost_q    <= PATH_COST_RST;
			root_id_q      <= BRIDGE_ID_RST;
			root_cost_q    <= '0;
			rpv_q          <= 1'b0;
			hello_q        <= 1'b1;
			better_q       <= 1'b0;
			found_q        <= 1'b0;
			do_upd_q       <= 1'b0;
			pend_v_q       <= 1'b0;
			pend_idx_q     <= '0;
			best_q         <= '0;
			rx_q           <= '0;
			rxp_q          <= '0;
			tx_valid_q     <= 1'b0;
			tx_port_q      <= '0;
			tx_root_id_q   <= '0;
			tx_root_cost_q <= '0;
			tx_port_id_q   <= '0;
			last_q         <= 1'b0;
		end else begin
			tx_valid_q <= ((state_q == ST_UPD) && emit_now && pend_v_q)
				|| ((state_q == ST_FLUSH) && pend_v_q);
			if (init_q) begin
				root_id_q   <= bridge_id_q;
				root_cost_q <= '0;
				rpv_q       <= 1'b0;
				hello_q     <= 1'b1;
			end
			init_q <= cfg_wr;
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[4:3]))
					REG_BRIDGE_ID: bridge_id_q <= pwdata;
					REG_PORT_PRIO: prio_q      <= pwdata[7:0];
					REG_PORTS_USE: ports_use_q <= pwdata[3:0];
					REG_PATH_COST: path_cost_q <= pwdata[15:0];
					default: bridge_id_q <= bridge_id_q;
				endcase
			end
			if (state_q != ST_IDLE && state_q != ST_FIN && state_q != ST_FLUSH) begin
				cnt_q <= last_cnt ? '0 : cnt_q + IW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rx_q     <= '{root: rx_root_id, cost: rx_root_cost,
							bridge: rx_bridge_id, did: rx_port_id};
						rxp_q    <= rx_port;
						better_q <= 1'b0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
						if (operation) begin
							do_upd_q <= 1'b0;
							if (hello_q) begin
								state_q <= ST_UPD;
							end
						end else if (rx_ok) begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (at_p) begin
						better_q <= better;
					end
					if (last_cnt) begin
						if (better_q || (at_p && better)) begin
							state_q <= ST_ELECT;
						end else begin
							pend_v_q   <= sendable;
							pend_idx_q <= IW'(rxp_q);
							state_q    <= ST_FLUSH;
						end
					end
				end
				ST_ELECT: begin
					if (in_use && !desig && (!found_q || wins)) begin
						best_q  <= head;
						found_q <= 1'b1;
					end
					if (last_cnt) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					rpv_q       <= found_q;
					root_id_q   <= nr_id;
					root_cost_q <= nr_cost;
					if (nr_id != bridge_id_q) begin
						hello_q <= 1'b0;
					end
					do_upd_q <= 1'b1;
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					if (emit_now) begin
						if (pend_v_q) begin
							tx_port_q      <= 3'(pend_idx_q);
							tx_root_id_q   <= root_id_q;
							tx_root_cost_q <= root_cost_q;
							tx_port_id_q   <= own_id(prio_q, 8'(pend_idx_q));
							last_q         <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_idx_q <= cnt_q;
					end
					if (last_cnt) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (pend_v_q) begin
						tx_port_q      <= 3'(pend_idx_q);
						tx_root_id_q   <= root_id_q;
						tx_root_cost_q <= root_cost_q;
						tx_port_id_q   <= own_id(prio_q, 8'(pend_idx_q));
						last_q         <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:3]))
			REG_BRIDGE_ID: prdata = bridge_id_q;
			REG_PORT_PRIO: prdata = {56'd0, prio_q};
			REG_PORTS_USE: prdata = {60'd0, ports_use_q};
			REG_PATH_COST: prdata = {48'd0, path_cost_q};
			default: prdata = '0;
		endcase
	end

	assign pready       = 1'b1;
	assign tx_valid     = tx_valid_q;
	assign tx_port      = tx_port_q;
	assign tx_root_id   = tx_root_id_q;
	assign tx_root_cost = tx_root_cost_q;
	assign tx_port_id   = tx_port_id_q;
	assign last         = last_q;

	`ASSERT_NEXT(a_accept_busy, accept && (operation ? hello_q : rx_ok), busy, "accepted item did not raise busy")
	`ASSERT_NEXT(a_cfg_reload, psel && penable && pwrite, busy, "register write did not reload")
	`ASSERT_NEXT(a_last_ends, tx_valid && last, !tx_valid, "transfer after last of run")

endmodule

// File: sv/stp_cbe_cell.sv
module stp_cbe_cell import stp_cbe_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  rec_t      init_rec,
	input  rec_t      nxt_rec,
	output rec_t      rec
);

	rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			rec_q <= init_rec;
		end else if (ctl.shift) begin
			rec_q <= nxt_rec;
		end
	end

	assign rec = rec_q;

endmodule

// File: tb/stp_tb_pkg.sv
package stp_tb_pkg;

	typedef enum logic {
		OP_RX_CONFIG = 1'b0,
		OP_HELLO     = 1'b1
	} bpdu_op_t;

	typedef struct packed {
		logic [2:0]  port;
		logic [63:0] root;
		logic [31:0] cost;
		logic [15:0] pid;
		logic        last;
	} tx_bpdu_t;

endpackage

// File: tb/stp_bpdu_checker.sv
module stp_bpdu_checker import stp_cbe_pkg::*; import stp_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [2:0]  rx_port,
	input  logic [63:0] rx_root_id,
	input  logic [31:0] rx_root_cost,
	input  logic [63:0] rx_bridge_id,
	input  logic [15:0] rx_port_id,
	input  logic        tx_valid,
	input  logic [2:0]  tx_port,
	input  logic [63:0] tx_root_id,
	input  logic [31:0] tx_root_cost,
	input  logic [15:0] tx_port_id,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          n_sent
);

	localparam int NP = 8;

	logic [63:0] br_id;
	logic [7:0]  prio;
	logic [3:0]  nports;
	logic [15:0] link_cost;

	logic [63:0] rec_root [NP];
	logic [31:0] rec_cost [NP];
	logic [63:0] rec_bridge [NP];
	logic [15:0] rec_did [NP];
	logic [63:0] cur_root;
	logic [31:0] cur_cost;
	logic        rp_valid;
	logic        hello_on;

	tx_bpdu_t bpdu_q[$];

	assign pending = bpdu_q.size();

	function automatic logic [15:0] port_ident(int i);
		logic [7:0] lo;
		lo = 8'(i + 1);
		return {prio, lo};
	endfunction

	function automatic int live_ports();
		if (nports == 0) return 1;
		if (nports > NP) return NP;
		return int'(nports);
	endfunction

	function automatic bit desig(int i);
		return rec_bridge[i] == br_id && rec_did[i] == port_ident(i);
	endfunction

	function automatic bit beats(int c, int b);
		if (rec_root[c] != rec_root[b]) return rec_root[c] < rec_root[b];
		if (rec_cost[c] != rec_cost[b]) return rec_cost[c] < rec_cost[b];
		if (rec_bridge[c] != rec_bridge[b])
			return !(rec_bridge[c][47:0] > rec_bridge[b][47:0]);
		if (rec_did[c] != rec_did[b]) return !(rec_did[c][7:0] > rec_did[b][7:0]);
		return 1'b1;
	endfunction

	task automatic reload_records();
		for (int i = 0; i < NP; i++) begin
			rec_root[i] = br_id;
			rec_cost[i] = '0;
			rec_bridge[i] = br_id;
			rec_did[i] = port_ident(i);
		end
		cur_root = br_id;
		cur_cost = '0;
		rp_valid = 1'b0;
		hello_on = 1'b1;
	endtask

	task automatic send_on(int i);
		tx_bpdu_t b;
		if (cur_root != br_id && !rp_valid) return;
		b.port = 3'(i);
		b.root = cur_root;
		b.cost = cur_cost;
		b.pid = port_ident(i);
		b.last = 1'b0;
		bpdu_q.push_back(b);
	endtask

	task automatic send_designated();
		for (int i = 0; i < live_ports(); i++)
			if (desig(i)) send_on(i);
	endtask

	task automatic process_item(bpdu_op_t op, int p, logic [63:0] r_root, logic [31:0] r_cost,
			logic [63:0] r_br, logic [15:0] r_pid);
		int before_n;
		int best;
		bit found;
		bit better;
		before_n = bpdu_q.size();
		best = 0;
		found = 0;
		better = 0;
		if (op == OP_HELLO) begin
			if (hello_on) send_designated();
		end else if (p < live_ports()) begin
			if (rec_root[p] != r_root) better = rec_root[p] > r_root;
			else if (rec_cost[p] != r_cost) better = rec_cost[p] > r_cost;
			else if (rec_bridge[p] != r_br) better = rec_bridge[p][47:0] > r_br[47:0];
			else if (rec_did[p] != r_pid) better = rec_did[p][7:0] > r_pid[7:0];
			if (!better) begin
				send_on(p);
			end else begin
				rec_root[p] = r_root;
				rec_cost[p] = r_cost;
				rec_bridge[p] = r_br;
				rec_did[p] = r_pid;
				for (int i = 0; i < live_ports(); i++) begin
					if (desig(i)) continue;
					if (!found) begin
						best = i;
						found = 1;
					end else if (beats(i, best)) begin
						best = i;
					end
				end
				if (!found) begin
					rp_valid = 1'b0;
					cur_root = br_id;
					cur_cost = '0;
				end else begin
					rp_valid = 1'b1;
					cur_root = rec_root[best];
					cur_cost = rec_cost[best] + 32'(link_cost);
				end
				for (int i = 0; i < live_ports(); i++) begin
					if (desig(i)) begin
						rec_root[i] = cur_root;
						rec_cost[i] = cur_cost;
					end else if (cur_cost < rec_cost[i] ||
							(cur_cost == rec_cost[i] && br_id < rec_bridge[i]) ||
							(cur_cost == rec_cost[i] && br_id == rec_bridge[i] &&
							port_ident(i) == rec_did[i])) begin
						rec_bridge[i] = br_id;
						rec_did[i] = port_ident(i);
						rec_root[i] = cur_root;
						rec_cost[i] = cur_cost;
					end
				end
				if (cur_root != br_id) hello_on = 1'b0;
				send_designated();
			end
		end
		if (bpdu_q.size() > before_n) bpdu_q[bpdu_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_bpdu_t e;
		if (!arst_n) begin
			br_id = BRIDGE_ID_RST;
			prio = PORT_PRIO_RST;
			nports = PORTS_USE_RST;
			link_cost = PATH_COST_RST;
			reload_records();
			bpdu_q.delete();
			errors = 0;
			n_sent = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:3]))
					REG_BRIDGE_ID: br_id = pwdata;
					REG_PORT_PRIO: prio = pwdata[7:0];
					REG_PORTS_USE: nports = pwdata[3:0];
					REG_PATH_COST: link_cost = pwdata[15:0];
					default: br_id = br_id;
				endcase
				reload_records();
			end
			if (start && !busy)
				process_item(bpdu_op_t'(operation), int'(rx_port), rx_root_id, rx_root_cost,
					rx_bridge_id, rx_port_id);
			if (tx_valid) begin
				n_sent++;
				if (bpdu_q.size() == 0) begin
					$error("unexpected config transfer on port %0d", tx_port);
					errors++;
				end else begin
					e = bpdu_q.pop_front();
					if (tx_port !== e.port) begin
						$error("tx_port: expected %0d, got %0d", e.port, tx_port);
						errors++;
					end
					if (tx_root_id !== e.root) begin
						$error("tx_root_id: expected %h, got %h", e.root, tx_root_id);
						errors++;
					end
					if (tx_root_cost !== e.cost) begin
						$error("tx_root_cost: expected %h, got %h", e.cost, tx_root_cost);
						errors++;
					end
					if (tx_port_id !== e.pid) begin
						$error("tx_port_id: expected %h, got %h", e.pid, tx_port_id);
						errors++;
					end
					if (last !== e.last) begin
						$error("last: expected %b, got %b", e.last, last);
						errors++;
					end
				end
			end
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top import stp_cbe_pkg::*; import stp_tb_pkg::*;;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = 1'b0;
	logic [2:0]  rx_port = '0;
	logic [63:0] rx_root_id = '0;
	logic [31:0] rx_root_cost = '0;
	logic [63:0] rx_bridge_id = '0;
	logic [15:0] rx_port_id = '0;
	logic        tx_valid;
	logic [2:0]  tx_port;
	logic [63:0] tx_root_id;
	logic [31:0] tx_root_cost;
	logic [15:0] tx_port_id;
	logic        last;
	int          errors, pending, n_sent;
	int          n_items = 0;
	int          idle_pct = 0;
	logic [63:0] my_id = '0;

	always #4 clk = ~clk;

	stp_config_bpdu_engine dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .operation(operation), .rx_port(rx_port),
		.rx_root_id(rx_root_id), .rx_root_cost(rx_root_cost), .rx_bridge_id(rx_bridge_id),
		.rx_port_id(rx_port_id), .tx_valid(tx_valid), .tx_port(tx_port),
		.tx_root_id(tx_root_id), .tx_root_cost(tx_root_cost), .tx_port_id(tx_port_id),
		.last(last)
	);

	stp_bpdu_checker chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .start(start), .busy(busy),
		.operation(operation), .rx_port(rx_port), .rx_root_id(rx_root_id),
		.rx_root_cost(rx_root_cost), .rx_bridge_id(rx_bridge_id), .rx_port_id(rx_port_id),
		.tx_valid(tx_valid), .tx_port(tx_port), .tx_root_id(tx_root_id),
		.tx_root_cost(tx_root_cost), .tx_port_id(tx_port_id), .last(last),
		.errors(errors), .pending(pending), .n_sent(n_sent)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic drain();
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t r, logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_BRIDGE_ID) my_id = v;
	endtask

	// start stays high across back-to-back transfers unless a random idle gap drops it
	task automatic issue(bpdu_op_t op, logic [2:0] p, logic [63:0] r, logic [31:0] c,
			logic [63:0] b, logic [15:0] pid);
		if ($urandom_range(99) < idle_pct) begin
			@(posedge clk);
			start <= 1'b0;
			repeat ($urandom_range(20, 1)) @(posedge clk);
		end else begin
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		rx_port <= p;
		rx_root_id <= r;
		rx_root_cost <= c;
		rx_bridge_id <= b;
		rx_port_id <= pid;
		@(negedge clk);
		while (busy) @(negedge clk);
		n_items++;
	endtask

	task automatic stop_issue();
		@(posedge clk);
		start <= 1'b0;
	endtask

	function automatic logic [63:0] pick_id();
		case ($urandom_range(7))
			0: return my_id;
			1: return my_id - 64'd1;
			2: return my_id + 64'd1;
			3: return my_id ^ (64'd1 << $urandom_range(63, 48));
			4: return 64'($urandom_range(3));
			5: return '1;
			6: return 64'd0;
			default: return rand64();
		endcase
	endfunction

	task automatic random_item();
		logic [31:0] c;
		logic [15:0] pid;
		case ($urandom_range(3))
			0: c = 32'd0;
			1: c = $urandom_range(8);
			2: c = '1 - $urandom_range(2);
			default: c = $urandom;
		endcase
		pid = ($urandom_range(3) == 0) ? 16'($urandom) : {8'($urandom), 8'($urandom_range(9))};
		if ($urandom_range(5) == 0)
			issue(OP_HELLO, 3'($urandom), rand64(), $urandom, rand64(), 16'($urandom));
		else
			issue(OP_RX_CONFIG, 3'($urandom), pick_id(), c, pick_id(), pid);
	endtask

	task automatic directed_items();
		issue(OP_HELLO, '0, '0, '0, '0, '0);
		issue(OP_RX_CONFIG, 3'd0, my_id, '0, my_id, 16'h8001);
		issue(OP_RX_CONFIG, 3'd1, 64'd1, 32'd5, 64'd10, 16'h8001);
		issue(OP_HELLO, '0, '0, '0, '0, '0);
		issue(OP_RX_CONFIG, 3'd1, 64'd1, 32'd5, 64'd10, 16'h8001);
		issue(OP_RX_CONFIG, 3'd2, 64'd1, 32'd5, 64'd10 | (64'd1 << 60), 16'h8001);
		issue(OP_RX_CONFIG, 3'd4, 64'd1, 32'd5, 64'd10, 16'h0001);
		issue(OP_RX_CONFIG, 3'd3, 64'd1, 32'hffffffff, 64'd3, 16'h0003);
		issue(OP_RX_CONFIG, 3'd7, '1, '1, '1, '1);
		issue(OP_RX_CONFIG, 3'd0, '0, '0, '0, '0);
		issue(OP_RX_CONFIG, 3'd5, '0, '0, '0, 16'hffff);
		issue(OP_RX_CONFIG, 3'd6, 64'd0, 32'd0, 64'd0, 16'h0000);
		issue(OP_HELLO, '0, '0, '0, '0, '0);
		stop_issue();
	endtask

	task automatic run_phase(int pct, int count, bit hold);
		idle_pct = pct;
		for (int k = 0; k < count; k++) begin
			random_item();
			if (hold && k == count / 2) begin
				stop_issue();
				drain();
			end
		end
		stop_issue();
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(0, 30, 1'b0);

		reg_write(REG_BRIDGE_ID, 64'h8000_0011_2233_4455);
		reg_write(REG_PATH_COST, 64'd4);
		directed_items();
		drain();
		run_phase(85, 40, 1'b1);

		reg_write(REG_BRIDGE_ID, '1);
		reg_write(REG_PORT_PRIO, 64'hff);
		reg_write(REG_PATH_COST, 64'hffff);
		run_phase(0, 40, 1'b0);

		reg_write(REG_BRIDGE_ID, '0);
		reg_write(REG_PORT_PRIO, 64'h0);
		reg_write(REG_PORTS_USE, 64'd1);
		reg_write(REG_PATH_COST, 64'd0);
		run_phase(27, 30, 1'b0);

		reg_write(REG_BRIDGE_ID, rand64());
		reg_write(REG_PORT_PRIO, 64'($urandom_range(255)));
		reg_write(REG_PORTS_USE, 64'd15);
		reg_write(REG_PATH_COST, 64'($urandom_range(65535)));
		run_phase(85, 40, 1'b0);

		reg_write(REG_PORTS_USE, 64'd0);
		reg_write(REG_PORT_PRIO, 64'd200);
		run_phase(0, 20, 1'b0);

		reg_write(REG_BRIDGE_ID, 64'h0123_4567_89ab_cdef);
		reg_write(REG_PORTS_USE, 64'd3);
		reg_write(REG_PATH_COST, 64'd100);
		run_phase(27, 40, 1'b0);

		repeat (40) @(posedge clk);
		$display("Run: %0d items over 7 register settings, %0d config transfers checked",
			n_items, n_sent);
		$display("Covered: hello ticks, ignored ports, ties, high-bit bridge ids, cost wrap");
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
